>>> rtl/stt_pkg.sv
// shared types and constants of the software timer table
package stt_pkg;

    localparam int unsigned MAX_FIRE = 16;
    localparam int unsigned FCW      = $clog2(MAX_FIRE + 1);

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_REMOVE = 2'd1,
        K_TICK   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_EVAL,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] action;
        logic [31:0] context_w;
        logic [31:0] stamp;
        logic [15:0] period;
        logic        rpt;
    } t_entry;

    typedef struct packed {
        logic load;
        logic add_go;
        logic read_go;
        logic eval_go;
        logic flush_go;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_kind;
        logic       more;
        logic       add_ok;
        logic       eval_ok;
        logic       flush_ok;
    } t_stat;

endpackage

>>> rtl/stt_ctrl.sv
// controller state machine of the software timer table
module stt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  stt_pkg::t_stat i_stat,
    output logic          o_ready,
    output stt_pkg::t_cmd o_cmd
);
    import stt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_stat.in_kind)
                        K_ADD:           n_state = S_ADD;
                        K_REMOVE, K_TICK: n_state = S_SCAN;
                        default:         n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD:   if (i_stat.add_ok) n_state = S_IDLE;
            S_SCAN:  n_state = i_stat.more ? S_EVAL : S_FLUSH;
            S_EVAL:  if (i_stat.eval_ok) n_state = S_SCAN;
            S_FLUSH: if (i_stat.flush_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_ADD:   o_cmd.add_go   = i_stat.add_ok;
            S_SCAN:  o_cmd.read_go  = i_stat.more;
            S_EVAL:  o_cmd.eval_go  = i_stat.eval_ok;
            S_FLUSH: o_cmd.flush_go = i_stat.flush_ok;
            default: o_ready = 1'b0;
        endcase
    end

endmodule

>>> rtl/stt_dp.sv
// datapath of the software timer table: table memory, scan pointers, result registers
module stt_dp #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stt_pkg::t_cmd  i_cmd,
    output stt_pkg::t_stat o_stat,
    input  logic [1:0]     i_kind,
    input  logic [31:0]    i_now_ms,
    input  logic [15:0]    i_interval_ms,
    input  logic           i_repeat_req,
    input  logic [15:0]    i_action_tag,
    input  logic [31:0]    i_context_req,
    input  logic [15:0]    i_handle,
    input  logic           i_ready,
    output logic           o_valid,
    output logic [1:0]     o_result_kind,
    output logic [15:0]    o_timer_id,
    output logic [15:0]    o_action_out,
    output logic [31:0]    o_context_out,
    output logic           o_ok,
    output logic           o_last
);
    import stt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // request held for the length of the item
    logic [1:0]  r_kind;
    logic [31:0] r_now;
    logic [15:0] r_interval;
    logic        r_rpt;
    logic [15:0] r_action;
    logic [31:0] r_context;
    logic [15:0] r_handle;

    logic [CW-1:0]  r_used;
    logic [CW-1:0]  r_rd;
    logic [CW-1:0]  r_wr;
    logic [FCW-1:0] r_cnt;
    logic [15:0]    r_next_id;
    logic           r_found;

    // staged fire result, sent once the next one or the end of the scan is known
    logic        r_stg_valid;
    logic [15:0] r_stg_id;
    logic [15:0] r_stg_action;
    logic [31:0] r_stg_context;

    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [15:0] r_out_id;
    logic [15:0] r_out_action;
    logic [31:0] r_out_context;
    logic        r_out_ok;
    logic        r_out_last;

    logic        out_free;
    logic        full;
    logic [31:0] elapsed;
    logic        due;
    logic        fire;
    logic        match;
    logic        is_tick;
    logic        keep;
    logic        we;
    logic [AW-1:0] waddr;
    t_entry      wdata;
    logic        push;
    logic [1:0]  push_kind;
    logic [15:0] push_id;
    logic [15:0] push_action;
    logic [31:0] push_context;
    logic        push_ok;
    logic        push_last;

    assign out_free = !r_out_valid || i_ready;
    assign full     = (r_used == CW'(DEPTH));
    assign is_tick  = (r_kind == K_TICK);
    assign elapsed  = r_now - r_rdata.stamp;
    assign due      = (r_rdata.period == 16'd0) || (elapsed >= {16'd0, r_rdata.period});
    assign fire     = is_tick && due && (r_cnt < FCW'(MAX_FIRE));
    assign match    = !is_tick && !r_found && (r_rdata.id == r_handle);
    assign keep     = !match && !(fire && !r_rdata.rpt);

    always_comb begin
        o_stat.in_kind  = i_kind;
        o_stat.more     = (r_rd < r_used);
        o_stat.add_ok   = out_free;
        o_stat.eval_ok  = !(fire && r_stg_valid && !out_free);
        o_stat.flush_ok = out_free || (is_tick && !r_stg_valid);
    end

    // write port: append on add, compact on scan
    always_comb begin
        we    = 1'b0;
        waddr = r_wr[AW-1:0];
        wdata = r_rdata;
        if (i_cmd.add_go) begin
            we              = !full;
            waddr           = r_used[AW-1:0];
            wdata.id        = r_next_id;
            wdata.action    = r_action;
            wdata.context_w = r_context;
            wdata.stamp     = r_now;
            wdata.period    = r_interval;
            wdata.rpt       = r_rpt;
        end else if (i_cmd.eval_go) begin
            we = keep;
            if (fire) begin
                wdata.stamp = r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.read_go) begin
            r_rdata <= r_mem[r_rd[AW-1:0]];
        end
    end

    // result to the output register
    always_comb begin
        push         = 1'b0;
        push_kind    = K_TICK;
        push_id      = r_stg_id;
        push_action  = r_stg_action;
        push_context = r_stg_context;
        push_ok      = 1'b1;
        push_last    = 1'b0;
        if (i_cmd.add_go) begin
            push         = 1'b1;
            push_kind    = K_ADD;
            push_id      = full ? 16'd0 : r_next_id;
            push_action  = 16'd0;
            push_context = 32'd0;
            push_ok      = !full;
            push_last    = 1'b1;
        end else if (i_cmd.eval_go) begin
            push = fire && r_stg_valid;
        end else if (i_cmd.flush_go) begin
            push_last = 1'b1;
            if (is_tick) begin
                push = r_stg_valid;
            end else begin
                push         = 1'b1;
                push_kind    = K_REMOVE;
                push_id      = r_handle;
                push_action  = 16'd0;
                push_context = 32'd0;
                push_ok      = r_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_kind;
            r_now      <= i_now_ms;
            r_interval <= i_interval_ms;
            r_rpt      <= i_repeat_req;
            r_action   <= i_action_tag;
            r_context  <= i_context_req;
            r_handle   <= i_handle;
        end
        if (i_cmd.eval_go && fire) begin
            r_stg_id      <= r_rdata.id;
            r_stg_action  <= r_rdata.action;
            r_stg_context <= r_rdata.context_w;
        end
        if (push) begin
            r_out_kind    <= push_kind;
            r_out_id      <= push_id;
            r_out_action  <= push_action;
            r_out_context <= push_context;
            r_out_ok      <= push_ok;
            r_out_last    <= push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_next_id   <= 16'd1;
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_rd        <= '0;
                r_wr        <= '0;
                r_cnt       <= '0;
                r_found     <= 1'b0;
                r_stg_valid <= 1'b0;
            end
            if (i_cmd.add_go && !full) begin
                r_used    <= r_used + CW'(1);
                r_next_id <= r_next_id + 16'd1;
            end
            if (i_cmd.eval_go) begin
                r_rd <= r_rd + CW'(1);
                if (keep) begin
                    r_wr <= r_wr + CW'(1);
                end
                if (match) begin
                    r_found <= 1'b1;
                end
                if (fire) begin
                    r_cnt       <= r_cnt + FCW'(1);
                    r_stg_valid <= 1'b1;
                end
            end
            if (i_cmd.flush_go) begin
                r_used      <= r_wr;
                r_stg_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_timer_id    = r_out_id;
    assign o_action_out  = r_out_action;
    assign o_context_out = r_out_context;
    assign o_ok          = r_out_ok;
    assign o_last        = r_out_last;

endmodule

>>> rtl/software_timer_table.sv
// top level of the software timer table
//
//  channel   direction  handshake          payload
//  request   in         i_valid / o_ready  i_kind i_now_ms i_interval_ms i_repeat_req
//                                          i_action_tag i_context_req i_handle
//  result    out        o_valid / i_ready  o_result_kind o_timer_id o_action_out
//                                          o_context_out o_ok o_last
//
// one request at a time; an add is a single append, a remove or tick scans the N stored
// timers one by one through the single read port of the table memory
// (read an entry, then evaluate and compact it, then an end-of-scan check and a final result)
// a stalled result register holds the scan until it is taken
// reset (synchronous, active low) empties the table and sets the next id to one;
// no clearing pass, the fill count alone marks which entries hold timers
module software_timer_table #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_interval_ms,
    input  logic        i_repeat_req,
    input  logic [15:0] i_action_tag,
    input  logic [31:0] i_context_req,
    input  logic [15:0] i_handle,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [15:0] o_timer_id,
    output logic [15:0] o_action_out,
    output logic [31:0] o_context_out,
    output logic        o_ok,
    output logic        o_last
);
    import stt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: idle, append, scan read, scan evaluate, final result
    stt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    // table memory, compaction pointers and the result registers
    stt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (i_kind),
        .i_now_ms      (i_now_ms),
        .i_interval_ms (i_interval_ms),
        .i_repeat_req  (i_repeat_req),
        .i_action_tag  (i_action_tag),
        .i_context_req (i_context_req),
        .i_handle      (i_handle),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_result_kind (o_result_kind),
        .o_timer_id    (o_timer_id),
        .o_action_out  (o_action_out),
        .o_context_out (o_context_out),
        .o_ok          (o_ok),
        .o_last        (o_last)
    );

endmodule

>>> rtl/stt_chk.sv
// port checker of the software timer table and its bind
module stt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_result_kind,
    input logic [15:0] o_timer_id,
    input logic        o_ok,
    input logic        o_last
);
    import stt_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_timer_id) && $stable(o_last))
        else $error("stalled result changed");

    // acknowledges are single results
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == K_ADD || o_result_kind == K_REMOVE) |-> o_last)
        else $error("acknowledge without last");

    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == K_TICK |-> o_ok)
        else $error("fired result without ok");

    // refused add returns a zero id
    a_full_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == K_ADD && !o_ok |-> o_timer_id == 16'd0)
        else $error("refused add with nonzero id");

endmodule

bind software_timer_table stt_chk u_stt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_result_kind (o_result_kind),
    .o_timer_id    (o_timer_id),
    .o_ok          (o_ok),
    .o_last        (o_last)
);

>>> sim/software_timer_table_checker.sv
// request and result monitor with the timer table predictor and result comparison
`timescale 1ns / 100ps

module software_timer_table_checker #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_interval_ms,
    input  logic        i_repeat_req,
    input  logic [15:0] i_action_tag,
    input  logic [31:0] i_context_req,
    input  logic [15:0] i_handle,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_result_kind,
    input  logic [15:0] i_timer_id,
    input  logic [15:0] i_action_out,
    input  logic [31:0] i_context_out,
    input  logic        i_ok,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending
);
    import stt_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] id;
        logic [15:0] act;
        logic [31:0] ctx;
        logic        ok;
        logic        last;
    } t_result;

    t_entry      timers[DEPTH];
    int          used;
    logic [15:0] id_counter;
    t_result     due_results[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        o_errors++;
    endtask

    function automatic void drop_timer(input int k);
        for (int j = k; j + 1 < used; j++) timers[j] = timers[j + 1];
        used--;
    endfunction

    function automatic void push_result(input logic [1:0] kind, input logic [15:0] id,
                                        input logic [15:0] act, input logic [31:0] ctx,
                                        input logic ok);
        t_result r;
        r = '{kind: kind, id: id, act: act, ctx: ctx, ok: ok, last: 1'b1};
        due_results.push_back(r);
    endfunction

    // timer table behaviour per accepted request
    function automatic void predict_timer_table();
        int          k;
        int          fired;
        logic        found;
        logic [31:0] elapsed;
        case (i_kind)
            K_ADD: begin
                if (used >= DEPTH) begin
                    push_result(K_ADD, '0, '0, '0, 1'b0);
                end else begin
                    timers[used] = '{id: id_counter, action: i_action_tag,
                                     context_w: i_context_req, stamp: i_now_ms,
                                     period: i_interval_ms, rpt: i_repeat_req};
                    used++;
                    push_result(K_ADD, id_counter, '0, '0, 1'b1);
                    id_counter++;
                end
            end
            K_REMOVE: begin
                found = 1'b0;
                for (k = 0; k < used; k++) begin
                    if (timers[k].id == i_handle) begin
                        drop_timer(k);
                        found = 1'b1;
                        break;
                    end
                end
                push_result(K_REMOVE, i_handle, '0, '0, found);
            end
            K_TICK: begin
                fired = 0;
                k = 0;
                while (k < used) begin
                    elapsed = i_now_ms - timers[k].stamp;
                    if ((timers[k].period == 0 || elapsed >= 32'(timers[k].period))
                            && fired < MAX_FIRE) begin
                        push_result(K_TICK, timers[k].id, timers[k].action,
                                    timers[k].context_w, 1'b1);
                        due_results[$].last = 1'b0;
                        fired++;
                        if (timers[k].rpt) begin
                            timers[k].stamp = i_now_ms;
                            k++;
                        end else begin
                            drop_timer(k);
                        end
                    end else begin
                        k++;
                    end
                end
                if (fired > 0) due_results[$].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            used = 0;
            id_counter = 16'd1;
            due_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (due_results.size() == 0) begin
                    report("unexpected result", 32'(i_timer_id), 32'd0);
                end else begin
                    want = due_results.pop_front();
                    if (i_result_kind !== want.kind)
                        report("result_kind", 32'(i_result_kind), 32'(want.kind));
                    if (i_timer_id !== want.id)
                        report("timer_id", 32'(i_timer_id), 32'(want.id));
                    if (i_action_out !== want.act)
                        report("action_out", 32'(i_action_out), 32'(want.act));
                    if (i_context_out !== want.ctx)
                        report("context_out", i_context_out, want.ctx);
                    if (i_ok !== want.ok) report("ok", 32'(i_ok), 32'(want.ok));
                    if (i_last !== want.last) report("last", 32'(i_last), 32'(want.last));
                end
            end
            if (i_valid && i_ready_in) predict_timer_table();
        end
        o_pending = due_results.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

endmodule

>>> sim/software_timer_table_tb.sv
// stimulus and verdict for the software timer table
`timescale 1ns / 100ps

module software_timer_table_tb;
    import stt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_kind;
    logic [31:0] i_now_ms;
    logic [15:0] i_interval_ms;
    logic        i_repeat_req;
    logic [15:0] i_action_tag;
    logic [31:0] i_context_req;
    logic [15:0] i_handle;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_result_kind;
    logic [15:0] o_timer_id;
    logic [15:0] o_action_out;
    logic [31:0] o_context_out;
    logic        o_ok;
    logic        o_last;

    int          errors;
    int          pending;

    // idling odds in percent, and the long result hold-off
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_results;

    // ids handed out so far, used to aim removes at ids that were issued
    logic [15:0] issued_ids[$];
    logic [31:0] clock_ms;

    software_timer_table i_dut (.*);

    software_timer_table_checker i_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_ready_in    (o_ready),
        .i_kind        (i_kind),
        .i_now_ms      (i_now_ms),
        .i_interval_ms (i_interval_ms),
        .i_repeat_req  (i_repeat_req),
        .i_action_tag  (i_action_tag),
        .i_context_req (i_context_req),
        .i_handle      (i_handle),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_result_kind (o_result_kind),
        .i_timer_id    (o_timer_id),
        .i_action_out  (o_action_out),
        .i_context_out (o_context_out),
        .i_ok          (o_ok),
        .i_last        (o_last),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // result side: random stalls, or a solid hold-off while the block backs up
    always @(negedge i_clk) begin
        i_ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
    end

    // note the ids that adds really got
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready && o_result_kind == K_ADD && o_ok) begin
            issued_ids.push_back(o_timer_id);
        end
    end

    // one request: optional gap first, then hold it until the block takes it
    task automatic send_request(input logic [1:0] kind, input logic [31:0] now,
                                input logic [15:0] interval, input logic rpt,
                                input logic [15:0] act, input logic [31:0] ctx,
                                input logic [15:0] handle);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_kind        = kind;
        i_now_ms      = now;
        i_interval_ms = interval;
        i_repeat_req  = rpt;
        i_action_tag  = act;
        i_context_req = ctx;
        i_handle      = handle;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic random_request();
        int          pick;
        logic [15:0] handle;
        pick = $urandom_range(99);
        clock_ms += $urandom_range(40);
        if ($urandom_range(49) == 0) clock_ms = $urandom;
        if (pick < 40) begin
            send_request(K_ADD, clock_ms,
                         ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(60)),
                         1'($urandom_range(1)), 16'($urandom), $urandom, 16'($urandom));
        end else if (pick < 65) begin
            if (issued_ids.size() != 0 && $urandom_range(9) < 7)
                handle = issued_ids[$urandom_range(issued_ids.size() - 1)];
            else
                handle = 16'($urandom);
            send_request(K_REMOVE, $urandom, 16'($urandom), 1'($urandom_range(1)),
                         16'($urandom), $urandom, handle);
        end else if (pick < 95) begin
            send_request(K_TICK, clock_ms, 16'($urandom), 1'($urandom_range(1)),
                         16'($urandom), $urandom, 16'($urandom));
        end else begin
            // kind three: the block drops it
            send_request(2'd3, $urandom, 16'($urandom), 1'($urandom_range(1)),
                         16'($urandom), $urandom, 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_kind        = K_ADD;
        i_now_ms      = '0;
        i_interval_ms = '0;
        i_repeat_req  = 1'b0;
        i_action_tag  = '0;
        i_context_req = '0;
        i_handle      = '0;
        i_ready       = 1'b0;
        hold_results  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        clock_ms      = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero interval fires every tick, extremes, one-shot removal
        send_request(K_ADD, 32'd0, 16'd0, 1'b1, 16'h0001, 32'h0000_0001, '0);
        send_request(K_ADD, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(K_ADD, 32'd0, 16'd5, 1'b0, 16'h5A5A, 32'hA5A5_A5A5, '0);
        send_request(K_TICK, 32'd0, '0, 1'b0, '0, '0, '0);
        send_request(K_TICK, 32'd5, '0, 1'b0, '0, '0, '0);
        // elapsed across the 32-bit wrap
        send_request(K_ADD, 32'hFFFF_FFFE, 16'd4, 1'b0, 16'h1234, 32'h8765_4321, '0);
        send_request(K_TICK, 32'd1, '0, 1'b0, '0, '0, '0);
        send_request(K_TICK, 32'd2, '0, 1'b0, '0, '0, '0);
        // remove at the head keeps the rest in order, unknown id changes nothing
        send_request(K_REMOVE, '0, '0, 1'b0, '0, '0, 16'd1);
        send_request(K_REMOVE, '0, '0, 1'b0, '0, '0, 16'hFFFF);
        send_request(K_REMOVE, '0, '0, 1'b0, '0, '0, 16'd0);
        // quiet tick now that only the long timer is left
        send_request(K_TICK, 32'd3, '0, 1'b0, '0, '0, '0);
        send_request(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        // fill the table and add past full
        repeat (16) send_request(K_ADD, 32'd10, 16'd0, 1'b1, 16'($urandom), $urandom, '0);
        // a full tick: every stored timer fires
        send_request(K_TICK, 32'h0001_0010, '0, 1'b0, '0, '0, '0);
        wait_drained();

        // random phases with different idling on each side
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 8 : 0;
            for (int n = 0; n < 110; n++) begin
                if (phase == 0 && n == 40) begin
                    // results blocked for a long stretch while requests keep coming
                    fork
                        begin
                            hold_results = 1'b1;
                            repeat (300) @(negedge i_clk);
                            hold_results = 1'b0;
                        end
                        repeat (8) random_request();
                    join
                end
                if (n == 90) wait_drained();
                random_request();
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("software_timer_table test passed");
        end else begin
            $display("software_timer_table test failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("software_timer_table test failed");
        $finish;
    end

endmodule
